// ===== rtl/hpti_pkg.sv =====
// ----------------------------------------------------------------------------
// Helium property table interpolator: shared package
// Field widths, command and register codes, and property slot numbers.
// ----------------------------------------------------------------------------
package hpti_pkg;

   // Field widths of the item channels.
   localparam int TEMP_W  = 20;
   localparam int SEL_W   = 3;
   localparam int IDX_W   = 8;
   localparam int VAL_W   = 32;
   localparam int NU_W    = 32;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Number of property tables carried through the datapath.
   localparam int PROP_SLOTS = 7;
   localparam int PROP_ETA   = 0;
   localparam int PROP_RHO   = 1;

   // Command codes of an input item.
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TMIN        = 3'd0,
      CSR_TMAX        = 3'd1,
      CSR_GRID_STEP   = 3'd2,
      CSR_FIRST_ENTRY = 3'd3,
      CSR_LAST_ENTRY  = 3'd4,
      CSR_NU_MIN      = 3'd5,
      CSR_NU_MAX      = 3'd6
   } csr_index_type;

endpackage

// ===== rtl/hpti_req_if.sv =====
// ----------------------------------------------------------------------------
// Helium property table interpolator: request channel
// Valid/ready channel that carries load and evaluate items.
// ----------------------------------------------------------------------------
interface hpti_req_if
   import hpti_pkg::*;
   ();

   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic [TEMP_W-1:0]        temperature;
   logic [SEL_W-1:0]         table_select;
   logic [IDX_W-1:0]         entry_index;
   logic signed [VAL_W-1:0]  entry_value;

   modport source (
      output valid, cmd, temperature, table_select, entry_index, entry_value,
      input  ready
   );

   modport sink (
      input  valid, cmd, temperature, table_select, entry_index, entry_value,
      output ready
   );

endinterface

// ===== rtl/hpti_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Helium property table interpolator: response channel
// Valid/ready channel that carries one item of interpolated properties.
// ----------------------------------------------------------------------------
interface hpti_rsp_if
   import hpti_pkg::*;
   ();

   logic                     valid;
   logic                     ready;
   logic signed [VAL_W-1:0]  eta_value;
   logic signed [VAL_W-1:0]  rho_value;
   logic [NU_W-1:0]          nu_value;
   logic signed [VAL_W-1:0]  beta_value;
   logic signed [VAL_W-1:0]  gm_value;
   logic signed [VAL_W-1:0]  entropy_value;
   logic signed [VAL_W-1:0]  heat_capacity_value;
   logic signed [VAL_W-1:0]  inv_f_value;

   modport source (
      output valid, eta_value, rho_value, nu_value, beta_value, gm_value,
             entropy_value, heat_capacity_value, inv_f_value,
      input  ready
   );

   modport sink (
      input  valid, eta_value, rho_value, nu_value, beta_value, gm_value,
             entropy_value, heat_capacity_value, inv_f_value,
      output ready
   );

endinterface

// ===== rtl/hpti_div_pipe.sv =====
// ----------------------------------------------------------------------------
// Helium property table interpolator: pipelined divider
// Restoring division, one quotient bit per register stage, several lanes
// sharing one divisor, with a sideband payload that travels alongside.
// ----------------------------------------------------------------------------
module hpti_div_pipe #(
   parameter int LANES = 1,
   parameter int QW    = 32,
   parameter int DW    = 32,
   parameter int PW    = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [PW-1:0]               in_payload,
   input  logic [DW-1:0]               in_den,
   input  logic [LANES-1:0][DW-1:0]    in_rem,
   input  logic [LANES-1:0][QW-1:0]    in_num,
   output logic                        out_valid,
   output logic [PW-1:0]               out_payload,
   output logic [LANES-1:0][QW-1:0]    out_quo,
   output logic [LANES-1:0][DW-1:0]    out_rem
);

   logic                       valid_ff   [QW];
   logic [PW-1:0]              payload_ff [QW];
   logic [DW-1:0]              den_ff     [QW];
   logic [LANES-1:0][DW-1:0]   rem_ff     [QW];
   logic [LANES-1:0][QW-1:0]   num_ff     [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic                       valid_prev;
      logic [PW-1:0]              payload_prev;
      logic [DW-1:0]              den_prev;
      logic [LANES-1:0][DW-1:0]   rem_prev;
      logic [LANES-1:0][QW-1:0]   num_prev;
      logic [LANES-1:0][DW-1:0]   rem_in;
      logic [LANES-1:0][QW-1:0]   num_in;

      if (k == 0) begin : g_first
         assign valid_prev   = in_valid;
         assign payload_prev = in_payload;
         assign den_prev     = in_den;
         assign rem_prev     = in_rem;
         assign num_prev     = in_num;
      end else begin : g_next
         assign valid_prev   = valid_ff[k-1];
         assign payload_prev = payload_ff[k-1];
         assign den_prev     = den_ff[k-1];
         assign rem_prev     = rem_ff[k-1];
         assign num_prev     = num_ff[k-1];
      end

      // One restoring step per lane: bring down the next dividend bit, and
      // subtract the divisor where it fits. The quotient bit shifts in at
      // the bottom while the dividend bits shift out at the top.
      always_comb begin
         logic [DW:0] trial;
         trial = '0;
         for (int l = 0; l < LANES; l++) begin
            trial = {rem_prev[l], num_prev[l][QW-1]};
            if (trial >= {1'b0, den_prev}) begin
               rem_in[l] = DW'(trial - {1'b0, den_prev});
               num_in[l] = {num_prev[l][QW-2:0], 1'b1};
            end else begin
               rem_in[l] = trial[DW-1:0];
               num_in[l] = {num_prev[l][QW-2:0], 1'b0};
            end
         end
      end

      // Stage valid bit.
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      // Stage data.
      always_ff @(posedge clock) begin
         if (en) begin
            payload_ff[k] <= payload_prev;
            den_ff[k]     <= den_prev;
            rem_ff[k]     <= rem_in;
            num_ff[k]     <= num_in;
         end
      end
   end

   assign out_valid   = valid_ff[QW-1];
   assign out_payload = payload_ff[QW-1];
   assign out_quo     = num_ff[QW-1];
   assign out_rem     = rem_ff[QW-1];

`ifndef SYNTHESIS
   // A finished division leaves a remainder below its divisor.
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      out_valid && (den_ff[QW-1] != '0) |-> out_rem[0] < den_ff[QW-1])
      else $error("divider remainder not below divisor");

   // A held pipeline keeps its last stage.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !en |=> out_valid == $past(out_valid))
      else $error("divider output changed while stalled");

   // Reset empties the first stage.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !valid_ff[0])
      else $error("divider stage valid after reset");
`endif

endmodule

// ===== rtl/helium_property_table_interp_top.sv =====
// ----------------------------------------------------------------------------
// Helium property table interpolator: top level
// Seven property tables on one uniform temperature grid, linear
// interpolation, and kinematic viscosity as eta over rho.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries load items (cmd 0), which write one table entry and give
//   no result, and evaluate items (cmd 1), which give one rsp_ch item with
//   all seven interpolated properties and the clamped kinematic viscosity.
//   Registers are written through csr_we / csr_index / csr_wdata while the
//   block is idle; tables are loaded through req_ch before being evaluated.
//   The block takes one item per cycle unless the output queue is full.
//   An evaluate item passes through 20 stages of the grid index divider,
//   32 stages of the rounding divider for the interpolation, 32 stages of
//   the eta/rho divider, and nine address, table read, multiply and fixup
//   stages on its way to rsp_ch. Each table is a memory with one write and
//   two read ports, so both neighboring grid points come out in the same cycle.
//   A two-entry output queue sits in front of rsp_ch. When it is full the
//   whole pipeline holds and req_ch.ready drops; nothing is lost or repeated.
//   Reset empties the pipeline and queue and restores the register defaults;
//   table contents are not cleared.
// ----------------------------------------------------------------------------
module helium_property_table_interp_top
   import hpti_pkg::*;
#(
   parameter int TABLE_DEPTH    = 256,
   parameter int NUM_PROPERTIES = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   hpti_req_if.sink               req_ch,
   hpti_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int NT = (NUM_PROPERTIES < PROP_SLOTS) ? NUM_PROPERTIES : PROP_SLOTS;
   localparam int DEN_W  = TEMP_W + 1;
   localparam int PROD_W = VAL_W + 1 + DEN_W;
   localparam int MAG_W  = VAL_W + DEN_W;

   typedef enum logic [1:0] {
      NU_DIVIDE,
      NU_ZERO,
      NU_SAT
   } nu_mode_type;

   typedef struct packed {
      logic               eval;
      logic               below;
      logic               above;
      logic [SEL_W-1:0]   sel;
      logic [IDX_W-1:0]   idx;
      logic [VAL_W-1:0]   value;
   } a_side_type;

   typedef struct packed {
      logic [PROP_SLOTS-1:0]             neg;
      logic [PROP_SLOTS-1:0][VAL_W-1:0]  v0;
   } b_side_type;

   typedef struct packed {
      nu_mode_type                       mode;
      logic [PROP_SLOTS-1:0][VAL_W-1:0]  vals;
   } c_side_type;

   typedef struct packed {
      logic [PROP_SLOTS-1:0][VAL_W-1:0]  vals;
      logic [NU_W-1:0]                   nu;
   } rsp_item_type;

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [TEMP_W-1:0]  tmin_ff, tmax_ff, grid_step_ff;
   logic [IDX_W-1:0]   first_entry_ff, last_entry_ff;
   logic [NU_W-1:0]    nu_min_ff, nu_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tmin_ff        <= '0;
         tmax_ff        <= '1;
         grid_step_ff   <= TEMP_W'(4096);
         first_entry_ff <= '0;
         last_entry_ff  <= '1;
         nu_min_ff      <= '0;
         nu_max_ff      <= '1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TMIN:        tmin_ff        <= csr_wdata[TEMP_W-1:0];
            CSR_TMAX:        tmax_ff        <= csr_wdata[TEMP_W-1:0];
            CSR_GRID_STEP:   grid_step_ff   <= csr_wdata[TEMP_W-1:0];
            CSR_FIRST_ENTRY: first_entry_ff <= csr_wdata[IDX_W-1:0];
            CSR_LAST_ENTRY:  last_entry_ff  <= csr_wdata[IDX_W-1:0];
            CSR_NU_MIN:      nu_min_ff      <= csr_wdata[NU_W-1:0];
            CSR_NU_MAX:      nu_max_ff      <= csr_wdata[NU_W-1:0];
            default: ;
         endcase
      end
   end

   // Derived settings: a zero step acts as one, and entry registers
   // saturate at the last table row.
   logic [TEMP_W-1:0]  step_eff, depth_m1, first_w, last_w, lo_w, hi_w;
   logic [DEN_W-1:0]   den2;
   logic [AW-1:0]      lo_idx, hi_idx;

   always_comb begin
      step_eff = (grid_step_ff == '0) ? TEMP_W'(1) : grid_step_ff;
      den2     = {step_eff, 1'b0};
      depth_m1 = TEMP_W'(TABLE_DEPTH - 1);
      first_w  = TEMP_W'(first_entry_ff);
      last_w   = TEMP_W'(last_entry_ff);
      lo_w     = (first_w > depth_m1) ? depth_m1 : first_w;
      hi_w     = (last_w > depth_m1) ? depth_m1 : last_w;
      lo_idx   = AW'(lo_w);
      hi_idx   = AW'(hi_w);
   end

   // ------------------------------------------------------------------
   // Pipeline advance: the whole pipeline moves unless the output queue
   // is full.
   // ------------------------------------------------------------------
   logic [1:0] count_ff;
   logic       adv;

   assign adv          = (count_ff != 2'd2);
   assign req_ch.ready = adv;

   // ------------------------------------------------------------------
   // Stage 0: input register.
   // ------------------------------------------------------------------
   logic               s0_valid_ff, s0_cmd_ff;
   logic [TEMP_W-1:0]  s0_temp_ff;
   logic [SEL_W-1:0]   s0_sel_ff;
   logic [IDX_W-1:0]   s0_idx_ff;
   logic [VAL_W-1:0]   s0_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_cmd_ff   <= req_ch.cmd;
         s0_temp_ff  <= req_ch.temperature;
         s0_sel_ff   <= req_ch.table_select;
         s0_idx_ff   <= req_ch.entry_index;
         s0_value_ff <= req_ch.entry_value;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: range checks and offset from the grid start.
   // ------------------------------------------------------------------
   logic               s1_valid_ff;
   a_side_type         s1_side_ff;
   logic [TEMP_W-1:0]  s1_off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_side_ff.eval  <= (s0_cmd_ff == CMD_EVAL);
         s1_side_ff.below <= (s0_temp_ff < tmin_ff);
         s1_side_ff.above <= (s0_temp_ff > tmax_ff);
         s1_side_ff.sel   <= s0_sel_ff;
         s1_side_ff.idx   <= s0_idx_ff;
         s1_side_ff.value <= s0_value_ff;
         s1_off_ff        <= s0_temp_ff - tmin_ff;
      end
   end

   // ------------------------------------------------------------------
   // Grid index divider: offset / step gives the index and remainder.
   // ------------------------------------------------------------------
   logic                        a_valid;
   a_side_type                  a_side;
   logic [0:0][TEMP_W-1:0]      a_quo, a_rem;
   logic [$bits(a_side_type)-1:0] a_side_raw;

   hpti_div_pipe #(
      .LANES (1),
      .QW    (TEMP_W),
      .DW    (TEMP_W),
      .PW    ($bits(a_side_type))
   ) u_index_div (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_valid    (s1_valid_ff),
      .in_payload  (s1_side_ff),
      .in_den      (step_eff),
      .in_rem      ('0),
      .in_num      (s1_off_ff),
      .out_valid   (a_valid),
      .out_payload (a_side_raw),
      .out_quo     (a_quo),
      .out_rem     (a_rem)
   );

   assign a_side = a_side_type'(a_side_raw);

   // ------------------------------------------------------------------
   // Stage 2: table addresses, out-of-grid cases and load decode.
   // ------------------------------------------------------------------
   logic               s2_valid_ff, s2_eval_ff, s2_special_ff;
   logic [AW-1:0]      s2_addr0_ff, s2_addr1_ff;
   logic [TEMP_W-1:0]  s2_r_ff;
   logic               s2_wr_en_ff;
   logic [SEL_W-1:0]   s2_wsel_ff;
   logic [AW-1:0]      s2_waddr_ff;
   logic [VAL_W-1:0]   s2_wdata_ff;

   logic               s2_special_in, s2_wr_en_in;
   logic [AW-1:0]      s2_addr0_in, s2_addr1_in;

   always_comb begin
      s2_special_in = a_side.below || a_side.above || (a_quo[0] >= hi_w);
      if (a_side.below) begin
         s2_addr0_in = lo_idx;
      end else if (s2_special_in) begin
         s2_addr0_in = hi_idx;
      end else begin
         s2_addr0_in = AW'(a_quo[0]);
      end
      s2_addr1_in = s2_special_in ? s2_addr0_in : AW'(a_quo[0] + TEMP_W'(1));
      s2_wr_en_in = a_valid && !a_side.eval && (a_side.sel < SEL_W'(NT)) &&
                    (32'(a_side.idx) < 32'(TABLE_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= a_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_eval_ff    <= a_side.eval;
         s2_special_ff <= s2_special_in;
         s2_addr0_ff   <= s2_addr0_in;
         s2_addr1_ff   <= s2_addr1_in;
         s2_r_ff       <= s2_special_in ? '0 : a_rem[0];
         s2_wr_en_ff   <= s2_wr_en_in;
         s2_wsel_ff    <= a_side.sel;
         s2_waddr_ff   <= AW'(a_side.idx);
         s2_wdata_ff   <= a_side.value;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: property tables. Loads write here, in item order with the
   // reads of evaluate items; both neighboring entries are read at once.
   // ------------------------------------------------------------------
   logic               s3_valid_ff, s3_special_ff;
   logic [TEMP_W-1:0]  s3_r_ff;
   wire  [PROP_SLOTS-1:0][VAL_W-1:0] s3_rd0, s3_rd1;

   for (genvar p = 0; p < PROP_SLOTS; p++) begin : g_prop
      if (p < NT) begin : g_mem
         logic [VAL_W-1:0] mem [TABLE_DEPTH];
         logic [VAL_W-1:0] rd0_ff, rd1_ff;

         always_ff @(posedge clock) begin
            if (adv) begin
               if (s2_wr_en_ff && (s2_wsel_ff == SEL_W'(p))) begin
                  mem[s2_waddr_ff] <= s2_wdata_ff;
               end
               rd0_ff <= mem[s2_addr0_ff];
               rd1_ff <= mem[s2_addr1_ff];
            end
         end

         assign s3_rd0[p] = rd0_ff;
         assign s3_rd1[p] = rd1_ff;
      end else begin : g_absent
         // A property without a table reads as zero.
         assign s3_rd0[p] = '0;
         assign s3_rd1[p] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff && s2_eval_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_special_ff <= s2_special_ff;
         s3_r_ff       <= s2_r_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: difference between neighbors. Outside the grid the upper
   // neighbor is the entry itself, so the difference is zero.
   // ------------------------------------------------------------------
   logic                                s4_valid_ff;
   logic [TEMP_W-1:0]                   s4_r_ff;
   logic [PROP_SLOTS-1:0][VAL_W-1:0]    s4_v0_ff;
   logic [PROP_SLOTS-1:0][VAL_W:0]      s4_delta_ff;
   logic [PROP_SLOTS-1:0][VAL_W:0]      s4_delta_in;

   always_comb begin
      for (int l = 0; l < PROP_SLOTS; l++) begin
         if (s3_special_ff) begin
            s4_delta_in[l] = '0;
         end else begin
            s4_delta_in[l] = {s3_rd1[l][VAL_W-1], s3_rd1[l]} -
                             {s3_rd0[l][VAL_W-1], s3_rd0[l]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_r_ff     <= s3_r_ff;
         s4_v0_ff    <= s3_rd0;
         s4_delta_ff <= s4_delta_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: difference times remainder.
   // ------------------------------------------------------------------
   logic                                      s5_valid_ff;
   logic [PROP_SLOTS-1:0][VAL_W-1:0]          s5_v0_ff;
   logic signed [PROD_W-1:0]                  s5_prod_ff [PROP_SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_v0_ff <= s4_v0_ff;
         for (int l = 0; l < PROP_SLOTS; l++) begin
            s5_prod_ff[l] <= $signed(s4_delta_ff[l]) * $signed({1'b0, s4_r_ff});
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: rounding numerator 2*prod + step, split into sign and
   // magnitude for the unsigned divider.
   // ------------------------------------------------------------------
   logic                              s6_valid_ff;
   b_side_type                        s6_side_ff;
   logic [PROP_SLOTS-1:0][MAG_W-1:0]  s6_mag_ff;
   logic [PROP_SLOTS-1:0]             s6_neg_in;
   logic [PROP_SLOTS-1:0][MAG_W-1:0]  s6_mag_in;

   always_comb begin
      logic [PROD_W+1:0] num;
      logic [PROD_W+1:0] mag;
      num = '0;
      mag = '0;
      for (int l = 0; l < PROP_SLOTS; l++) begin
         num = {s5_prod_ff[l][PROD_W-1], s5_prod_ff[l], 1'b0} + (PROD_W+2)'(step_eff);
         s6_neg_in[l] = num[PROD_W+1];
         mag = s6_neg_in[l] ? (PROD_W+2)'(-num) : num;
         s6_mag_in[l] = mag[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_side_ff.neg <= s6_neg_in;
         s6_side_ff.v0  <= s5_v0_ff;
         s6_mag_ff      <= s6_mag_in;
      end
   end

   // ------------------------------------------------------------------
   // Rounding divider: magnitude / (2*step) on all seven properties.
   // ------------------------------------------------------------------
   logic [PROP_SLOTS-1:0][DEN_W-1:0]  b_rem_in;
   logic [PROP_SLOTS-1:0][VAL_W-1:0]  b_num_in;
   logic                              b_valid;
   logic [$bits(b_side_type)-1:0]     b_side_raw;
   b_side_type                        b_side;
   logic [PROP_SLOTS-1:0][VAL_W-1:0]  b_quo;
   logic [PROP_SLOTS-1:0][DEN_W-1:0]  b_rem;

   always_comb begin
      for (int l = 0; l < PROP_SLOTS; l++) begin
         b_rem_in[l] = s6_mag_ff[l][MAG_W-1:VAL_W];
         b_num_in[l] = s6_mag_ff[l][VAL_W-1:0];
      end
   end

   hpti_div_pipe #(
      .LANES (PROP_SLOTS),
      .QW    (VAL_W),
      .DW    (DEN_W),
      .PW    ($bits(b_side_type))
   ) u_round_div (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_valid    (s6_valid_ff),
      .in_payload  (s6_side_ff),
      .in_den      (den2),
      .in_rem      (b_rem_in),
      .in_num      (b_num_in),
      .out_valid   (b_valid),
      .out_payload (b_side_raw),
      .out_quo     (b_quo),
      .out_rem     (b_rem)
   );

   assign b_side = b_side_type'(b_side_raw);

   // ------------------------------------------------------------------
   // Stage 7: floor of a negative quotient, then add the lower entry.
   // ------------------------------------------------------------------
   logic                              s7_valid_ff;
   logic [PROP_SLOTS-1:0][VAL_W-1:0]  s7_val_ff;
   logic [PROP_SLOTS-1:0][VAL_W-1:0]  s7_val_in;

   always_comb begin
      logic [VAL_W:0]   qmag;
      logic [VAL_W+1:0] qs;
      logic [VAL_W+1:0] sum;
      qmag = '0;
      qs   = '0;
      sum  = '0;
      for (int l = 0; l < PROP_SLOTS; l++) begin
         qmag = {1'b0, b_quo[l]} + (VAL_W+1)'(b_side.neg[l] && (b_rem[l] != '0));
         qs   = b_side.neg[l] ? (VAL_W+2)'(-{1'b0, qmag}) : {1'b0, qmag};
         sum  = {{2{b_side.v0[l][VAL_W-1]}}, b_side.v0[l]} + qs;
         s7_val_in[l] = sum[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (adv) begin
         s7_valid_ff <= b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_val_ff <= s7_val_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 8: eta/rho setup: sign cases, magnitudes, overflow check.
   // ------------------------------------------------------------------
   logic               s8_valid_ff;
   c_side_type         s8_side_ff;
   logic [VAL_W-1:0]   s8_eta_mag_ff, s8_rho_mag_ff;
   logic [VAL_W-1:0]   eta_w, rho_w, eta_mag, rho_mag;
   logic               nu_ovf;
   nu_mode_type        nu_mode;

   always_comb begin
      eta_w   = s7_val_ff[PROP_ETA];
      rho_w   = s7_val_ff[PROP_RHO];
      eta_mag = eta_w[VAL_W-1] ? VAL_W'(-eta_w) : eta_w;
      rho_mag = rho_w[VAL_W-1] ? VAL_W'(-rho_w) : rho_w;
      // The quotient overflows 32 bits when the top half of |eta|<<16
      // already reaches the divisor.
      nu_ovf  = ({16'b0, eta_mag[VAL_W-1:16]} >= rho_mag);
      if (eta_w == '0) begin
         nu_mode = NU_ZERO;
      end else if (rho_w == '0) begin
         nu_mode = eta_w[VAL_W-1] ? NU_ZERO : NU_SAT;
      end else if (eta_w[VAL_W-1] != rho_w[VAL_W-1]) begin
         nu_mode = NU_ZERO;
      end else if (nu_ovf) begin
         nu_mode = NU_SAT;
      end else begin
         nu_mode = NU_DIVIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else if (adv) begin
         s8_valid_ff <= s7_valid_ff;
      end
   end

   // Only a real division feeds the divider a dividend; the other cases
   // send zero so the divider starts below any nonzero divisor.
   always_ff @(posedge clock) begin
      if (adv) begin
         s8_side_ff.mode <= nu_mode;
         s8_side_ff.vals <= s7_val_ff;
         s8_eta_mag_ff   <= (nu_mode == NU_DIVIDE) ? eta_mag : '0;
         s8_rho_mag_ff   <= rho_mag;
      end
   end

   // ------------------------------------------------------------------
   // Viscosity divider: (|eta| << 16) / |rho|.
   // ------------------------------------------------------------------
   logic                          c_valid;
   logic [$bits(c_side_type)-1:0] c_side_raw;
   c_side_type                    c_side;
   logic [0:0][VAL_W-1:0]         c_quo, c_rem;

   hpti_div_pipe #(
      .LANES (1),
      .QW    (VAL_W),
      .DW    (VAL_W),
      .PW    ($bits(c_side_type))
   ) u_nu_div (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_valid    (s8_valid_ff),
      .in_payload  (s8_side_ff),
      .in_den      (s8_rho_mag_ff),
      .in_rem      ({16'b0, s8_eta_mag_ff[VAL_W-1:16]}),
      .in_num      ({s8_eta_mag_ff[15:0], 16'b0}),
      .out_valid   (c_valid),
      .out_payload (c_side_raw),
      .out_quo     (c_quo),
      .out_rem     (c_rem)
   );

   assign c_side = c_side_type'(c_side_raw);

   // ------------------------------------------------------------------
   // Final: saturation, nu_max then nu_min clamp, into the output queue.
   // The remainder of the viscosity division is not needed.
   // ------------------------------------------------------------------
   rsp_item_type fin_item;
   logic [NU_W-1:0] nu_raw, nu_lim;

   always_comb begin
      case (c_side.mode)
         NU_ZERO:   nu_raw = '0;
         NU_SAT:    nu_raw = '1;
         NU_DIVIDE: nu_raw = c_quo[0];
         default:   nu_raw = (c_rem[0] == '0) ? c_quo[0] : c_quo[0];
      endcase
      nu_lim        = (nu_raw > nu_max_ff) ? nu_max_ff : nu_raw;
      fin_item.nu   = (nu_lim < nu_min_ff) ? nu_min_ff : nu_lim;
      fin_item.vals = c_side.vals;
   end

   // ------------------------------------------------------------------
   // Two-entry output queue.
   // ------------------------------------------------------------------
   rsp_item_type queue_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic         push, pop;

   assign push = adv && c_valid;
   assign pop  = (count_ff != 2'd0) && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= fin_item;
      end
   end

   assign rsp_ch.valid               = (count_ff != 2'd0);
   assign rsp_ch.eta_value           = queue_ff[rd_ptr_ff].vals[0];
   assign rsp_ch.rho_value           = queue_ff[rd_ptr_ff].vals[1];
   assign rsp_ch.beta_value          = queue_ff[rd_ptr_ff].vals[2];
   assign rsp_ch.gm_value            = queue_ff[rd_ptr_ff].vals[3];
   assign rsp_ch.entropy_value       = queue_ff[rd_ptr_ff].vals[4];
   assign rsp_ch.heat_capacity_value = queue_ff[rd_ptr_ff].vals[5];
   assign rsp_ch.inv_f_value         = queue_ff[rd_ptr_ff].vals[6];
   assign rsp_ch.nu_value            = queue_ff[rd_ptr_ff].nu;

`ifndef SYNTHESIS
   // The output queue never holds more than two items.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output queue overflow");

   // With ordered clamps, a delivered viscosity lies inside them.
   a_nu_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (nu_min_ff <= nu_max_ff) |->
         (rsp_ch.nu_value >= nu_min_ff) && (rsp_ch.nu_value <= nu_max_ff))
      else $error("viscosity outside clamp range");

   // A full queue that is not drained freezes the table read stage.
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) && !rsp_ch.ready |=> $stable(s3_valid_ff))
      else $error("pipeline moved while stalled");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Helium property table interpolator: self-checking testbench
// Fills the low entries of all seven property tables, then runs through
// several grid and clamp settings whose reads stay inside those entries.
// Each setting gets directed evaluate items at the grid edges and random
// load and evaluate items. A scoreboard computes every result on its own
// and checks it field by field. Both channels stall at random.
// ----------------------------------------------------------------------------
module testbench
   import hpti_pkg::*;
   ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = 256;
   localparam int NPROP        = 7;
   localparam int FILL_ENTRIES = 32;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN        = 120;
   localparam int RAND_ITEMS   = 38;

   // One set of interpolated properties.
   typedef struct {
      logic [31:0] eta;
      logic [31:0] rho;
      logic [31:0] nu;
      logic [31:0] beta;
      logic [31:0] gm;
      logic [31:0] entropy;
      logic [31:0] heat_cap;
      logic [31:0] inv_f;
   } prop_set_type;

   // Scoreboard: its own copy of the tables and registers, and the
   // property sets still waiting to come out of the block.
   class prop_scoreboard;
      bit signed [31:0] tables [NPROP][DEPTH];
      bit [19:0] tmin = 0, tmax = 20'hFFFFF, grid_step = 4096;
      bit [7:0]  first_entry = 0, last_entry = 255;
      bit [31:0] nu_min = 0, nu_max = 32'hFFFFFFFF;
      prop_set_type expected_props[$];
      int errors  = 0;
      int checked = 0;

      function void set_reg(csr_index_type idx, logic [31:0] data);
         case (idx)
            CSR_TMIN:        tmin        = data[19:0];
            CSR_TMAX:        tmax        = data[19:0];
            CSR_GRID_STEP:   grid_step   = data[19:0];
            CSR_FIRST_ENTRY: first_entry = data[7:0];
            CSR_LAST_ENTRY:  last_entry  = data[7:0];
            CSR_NU_MIN:      nu_min      = data;
            CSR_NU_MAX:      nu_max      = data;
            default: ;
         endcase
      endfunction

      function longint entry(int p, longint idx);
         return longint'(tables[p][idx]);
      endfunction

      // Linear interpolation on the grid, rounding half toward plus infinity.
      function longint interpolate(int p, bit [19:0] t);
         longint step, off, i, r, v0, v1, num, den;
         step = (grid_step == 0) ? 1 : grid_step;
         if (t < tmin) return entry(p, first_entry);
         if (t > tmax) return entry(p, last_entry);
         off = t - tmin;
         i = off / step;
         if (i >= last_entry) return entry(p, last_entry);
         r = off - i * step;
         v0 = entry(p, i);
         v1 = entry(p, i + 1);
         num = (v1 - v0) * r * 2 + step;
         den = 2 * step;
         if (num >= 0) return v0 + num / den;
         return v0 - ((-num + den - 1) / den);
      endfunction

      // Kinematic viscosity, saturated, then clamped with nu_min winning.
      function logic [31:0] viscosity(longint eta, longint rho);
         longint q;
         logic [31:0] nu;
         if (rho == 0) nu = (eta > 0) ? 32'hFFFFFFFF : 32'h0;
         else begin
            q = (eta * 65536) / rho;
            if (q < 0) nu = 0;
            else if (q > 64'hFFFFFFFF) nu = 32'hFFFFFFFF;
            else nu = q[31:0];
         end
         if (nu > nu_max) nu = nu_max;
         if (nu < nu_min) nu = nu_min;
         return nu;
      endfunction

      // Note one accepted request item.
      function void note_input(logic cmd, bit [19:0] t, bit [2:0] sel, bit [7:0] idx,
                               bit [31:0] val);
         prop_set_type e;
         longint eta, rho;
         if (cmd == CMD_LOAD) begin
            if (sel < NPROP) tables[sel][idx] = val;
            return;
         end
         eta = interpolate(PROP_ETA, t);
         rho = interpolate(PROP_RHO, t);
         e.eta      = eta[31:0];
         e.rho      = rho[31:0];
         e.nu       = viscosity(eta, rho);
         e.beta     = 32'(interpolate(2, t));
         e.gm       = 32'(interpolate(3, t));
         e.entropy  = 32'(interpolate(4, t));
         e.heat_cap = 32'(interpolate(5, t));
         e.inv_f    = 32'(interpolate(6, t));
         expected_props.push_back(e);
      endfunction

      function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (act_v !== exp_v) begin
            $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
            errors++;
         end
      endfunction

      // Check one accepted result item against the oldest expectation.
      function void check_result(prop_set_type a);
         prop_set_type e;
         if (expected_props.size() == 0) begin
            $error("result item with no expectation waiting");
            errors++;
            return;
         end
         e = expected_props.pop_front();
         checked++;
         compare("eta_value", e.eta, a.eta);
         compare("rho_value", e.rho, a.rho);
         compare("nu_value", e.nu, a.nu);
         compare("beta_value", e.beta, a.beta);
         compare("gm_value", e.gm, a.gm);
         compare("entropy_value", e.entropy, a.entropy);
         compare("heat_capacity_value", e.heat_cap, a.heat_cap);
         compare("inv_f_value", e.inv_f, a.inv_f);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   hpti_req_if req_bus ();
   hpti_rsp_if rsp_bus ();

   prop_scoreboard sb = new;
   int  items_sent = 0;
   int  idle_cycles = 0;
   bit  burst_mode = 1'b0;

   helium_property_table_interp_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Check result items and watch for a stalled run.
   always @(posedge clock) begin
      prop_set_type a;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         a.eta      = rsp_bus.eta_value;
         a.rho      = rsp_bus.rho_value;
         a.nu       = rsp_bus.nu_value;
         a.beta     = rsp_bus.beta_value;
         a.gm       = rsp_bus.gm_value;
         a.entropy  = rsp_bus.entropy_value;
         a.heat_cap = rsp_bus.heat_capacity_value;
         a.inv_f    = rsp_bus.inv_f_value;
         sb.check_result(a);
      end
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d cycles with no item moving", IDLE_LIMIT);
         $display("testbench: errors");
         $finish;
      end
   end

   // Result side: random stalls, none while in burst mode.
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         gap = burst_mode ? 0 : $urandom_range(0, 14);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   // Send one request item after a random gap and wait for its acceptance.
   task automatic send_item(logic cmd, bit [19:0] t, bit [2:0] sel, bit [7:0] idx,
                            bit [31:0] val);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.cmd          <= cmd;
      req_bus.temperature  <= t;
      req_bus.table_select <= sel;
      req_bus.entry_index  <= idx;
      req_bus.entry_value  <= val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_input(cmd, t, sel, idx, val);
      items_sent++;
   endtask

   task automatic evaluate(bit [19:0] t);
      send_item(CMD_EVAL, t, 3'($urandom), 8'($urandom), $urandom);
   endtask

   task automatic load(bit [2:0] sel, bit [7:0] idx, bit [31:0] val);
      send_item(CMD_LOAD, 20'($urandom), sel, idx, val);
   endtask

   // Table value: mostly random, sometimes an extreme or zero.
   function automatic bit [31:0] table_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return 32'($urandom_range(0, 2000)) - 1000;
         default: return $urandom;
      endcase
   endfunction

   // Let the pipeline drain, then let the queue settle.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (sb.expected_props.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   task automatic configure(bit [19:0] lo_t, bit [19:0] hi_t, bit [19:0] step,
                            bit [7:0] first, bit [7:0] last, bit [31:0] nlo,
                            bit [31:0] nhi);
      csr_write(CSR_TMIN, 32'(lo_t));
      csr_write(CSR_TMAX, 32'(hi_t));
      csr_write(CSR_GRID_STEP, 32'(step));
      csr_write(CSR_FIRST_ENTRY, 32'(first));
      csr_write(CSR_LAST_ENTRY, 32'(last));
      csr_write(CSR_NU_MIN, nlo);
      csr_write(CSR_NU_MAX, nhi);
      csr_we <= 1'b0;
   endtask

   // Directed edges of the grid, then random loads and evaluations.
   task automatic run_phase();
      bit [19:0] lo_t, hi_t, step;
      bit [19:0] t;
      lo_t = sb.tmin;
      hi_t = sb.tmax;
      step = sb.grid_step;
      evaluate(20'h00000);
      evaluate(20'hFFFFF);
      if (lo_t > 0) evaluate(lo_t - 20'd1);
      evaluate(lo_t);
      evaluate(hi_t);
      if (hi_t < 20'hFFFFF) evaluate(hi_t + 20'd1);
      evaluate(lo_t + step / 2);
      evaluate(lo_t + step);
      // An ignored load to the unused table slot.
      load(3'd7, 8'($urandom), $urandom);
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            load(3'($urandom), 8'($urandom), table_value());
         end else begin
            if (hi_t >= lo_t && $urandom_range(0, 4) != 0)
               t = lo_t + 20'($urandom_range(0, hi_t - lo_t));
            else
               t = 20'($urandom);
            evaluate(t);
         end
         if ($urandom_range(0, 39) == 0) burst_mode = ~burst_mode;
      end
      wait_idle();
   endtask

   initial begin
      reset         <= 1'b1;
      csr_we        <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.cmd          <= CMD_LOAD;
      req_bus.temperature  <= '0;
      req_bus.table_select <= '0;
      req_bus.entry_index  <= '0;
      req_bus.entry_value  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the low entries once; every setting below reads only those.
      burst_mode = 1'b1;
      for (int p = 0; p < NPROP; p++)
         for (int i = 0; i < FILL_ENTRIES; i++)
            load(3'(p), 8'(i), table_value());
      burst_mode = 1'b0;
      wait_idle();

      // Default grid with the last entry pulled down to the filled range.
      configure(20'h00000, 20'hFFFFF, 20'd4096, 8'd0, 8'd31, 32'h0, 32'hFFFFFFFF);
      run_phase();
      configure(20'd1000, 20'd1000 + 20'd300 * 20'd255, 20'd300, 8'd3, 8'd20,
                32'h0, 32'hFFFFFFFF);
      run_phase();
      configure(20'h00000, 20'hFFFFF, 20'd1, 8'd0, 8'd0, 32'h0, 32'h0);
      run_phase();
      // Crossed temperature range and crossed viscosity clamps.
      configure(20'd50000, 20'd20000, 20'hFFFFF, 8'd7, 8'd31,
                32'hFFFFFFFF, 32'h0);
      run_phase();
      configure(20'h10000, 20'hF0000, 20'd4096, 8'd10, 8'd28,
                32'h100, 32'h7FFFFFFF);
      run_phase();
      configure(20'h00000, 20'hFFFFF, 20'hFFFFF, 8'd0, 8'd255, 32'h0, 32'hFFFFFFFF);
      run_phase();
      configure(20'd1234, 20'd1234 + 20'd4096 * 20'd100, 20'd4096, 8'd0, 8'd31,
                32'd5, 32'h100000);
      run_phase();

      $display("sent %0d request items over seven register settings", items_sent);
      $display("checked %0d result items, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.expected_props.size() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/hpti_pkg.sv
rtl/hpti_req_if.sv
rtl/hpti_rsp_if.sv
rtl/hpti_div_pipe.sv
rtl/helium_property_table_interp_top.sv
tb/testbench.sv
